// ===== rtl/delta_of_delta_timestamp_encoder_unit_assert.svh =====
// Assertion macros used by the timestamp encoder controller.
`ifndef DELTA_OF_DELTA_TIMESTAMP_ENCODER_UNIT_ASSERT_SVH
`define DELTA_OF_DELTA_TIMESTAMP_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DODENC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DODENC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dodenc_pkg.sv =====
// Types and constants shared by the timestamp encoder modules.
package dodenc_pkg;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_ITEMS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZIGZAG_MODE  = 2'd2;

   localparam logic [7:0] SIGN_POS  = 8'h00;
   localparam logic [7:0] SIGN_NEG  = 8'h01;
   localparam logic [7:0] VAR_MORE  = 8'h80;
   localparam int unsigned SIGN_BIT = 63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_HDR,
      ST_CNT,
      ST_RAW,
      ST_DLT,
      ST_SGN,
      ST_VAR
   } dodenc_state_type;

   typedef enum logic [2:0] {
      SRC_HDR,
      SRC_CNT,
      SRC_RAW,
      SRC_DLT,
      SRC_SGN,
      SRC_VAR
   } dodenc_src_type;

   typedef struct packed {
      logic           load;
      logic           prep;
      logic           emit;
      dodenc_src_type src;
      logic [2:0]     idx;
      logic           run_last;
   } dodenc_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic first_item;
      logic blk0;
      logic blk1;
      logic zigzag;
      logic var_done;
   } dodenc_sts_type;

endpackage

// ===== rtl/delta_of_delta_timestamp_encoder_unit.sv =====
// Top level of the delta-of-delta timestamp encoder.
// The encoder takes one signed 64-bit timestamp per input word and turns it into a
// little-endian byte stream, one byte per output word. The first word of a stream
// emits an 8-byte header (total_items, then block_length); the first word of every
// block emits a 4-byte count and the raw 8-byte timestamp; the second word of a block
// emits its raw 8-byte delta; every later word emits its delta-of-delta as a base-128
// varint, zigzag coded or preceded by a sign byte depending on zigzag_mode. run_last
// marks the final byte caused by each input word and stream_end the final byte of the
// stream. One word is in flight at a time: an accepted word first passes through the
// prepare step (the delta is formed at acceptance, the delta-of-delta and varint value
// in the prepare step) and then yields one output byte per cycle while the output
// register is free, from 1 to 20 bytes per word. The byte sequencer in the controller
// sets that pace, and a stalled output port holds the sequencer for as long as it
// stalls. The final output byte sits in a register, so the next timestamp is
// taken while that byte still waits to be read. Configuration is written through the
// csr port while the encoder is idle: index 0 total_items, 1 block_length,
// 2 zigzag_mode (bit 0 of the data); other indexes are ignored.
module delta_of_delta_timestamp_encoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dodenc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dodenc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [63:0]                req_stamp,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_run_last,
   output logic                              rsp_stream_end
);

   // Commands flow from the controller to the datapath; status flows back.
   dodenc_pkg::dodenc_cmd_type cmd;
   dodenc_pkg::dodenc_sts_type sts;

   // The controller owns the handshake on the input side and walks through the
   // header, count, raw, delta, sign and varint fields of the current word.
   dodenc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the stream and block positions, the
   // previous timestamp and delta, and the registered output byte.
   dodenc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_stamp      (req_stamp),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

// ===== rtl/dodenc_dp.sv =====
// Datapath of the timestamp encoder: registers, arithmetic, byte select, output word.
module dodenc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dodenc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dodenc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic signed [63:0]                   req_stamp,
   input  dodenc_pkg::dodenc_cmd_type           cmd,
   output dodenc_pkg::dodenc_sts_type           sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_run_last,
   output logic                                 rsp_stream_end
);

   logic [31:0] total_items_ff, block_length_ff;
   logic        zigzag_ff;
   logic [31:0] stream_idx_ff, block_idx_ff;
   logic [63:0] prior_stamp_ff, prior_delta_ff;
   logic [63:0] stamp_ff, delta_ff, vval_ff;
   logic [31:0] count_ff;
   logic        neg_ff, first_ff, blk0_ff, blk1_ff, ends_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, byte_in;
   logic        rsp_last_ff, rsp_end_ff;

   logic [31:0] total_eff, block_eff, remain, count_in;
   logic [32:0] stream_nxt, block_nxt;
   logic        ends_in, blk_wrap;
   logic [63:0] delta_in, dod, ndod, vval_in;
   logic        var_done;

   // Zero-valued registers are sequenced as if they were one.
   assign total_eff  = (total_items_ff == 32'd0) ? 32'd1 : total_items_ff;
   assign block_eff  = (block_length_ff == 32'd0) ? 32'd1 : block_length_ff;
   assign stream_nxt = {1'b0, stream_idx_ff} + 33'd1;
   assign block_nxt  = {1'b0, block_idx_ff} + 33'd1;
   assign ends_in    = stream_nxt >= {1'b0, total_eff};
   assign blk_wrap   = block_nxt >= {1'b0, block_eff};
   assign remain     = (stream_idx_ff < total_eff) ? (total_eff - stream_idx_ff) : 32'd1;
   assign count_in   = (remain < block_eff) ? remain : block_eff;
   assign delta_in   = $unsigned(req_stamp) - prior_stamp_ff;

   // Both differences are formed side by side, so the magnitude needs no second adder.
   assign dod  = delta_ff - prior_delta_ff;
   assign ndod = prior_delta_ff - delta_ff;
   always_comb begin
      if (zigzag_ff) begin
         vval_in = {dod[62:0], 1'b0} ^ {64{dod[dodenc_pkg::SIGN_BIT]}};
      end else if (dod[dodenc_pkg::SIGN_BIT]) begin
         vval_in = ndod;
      end else begin
         vval_in = dod;
      end
   end

   assign var_done = (vval_ff[63:7] == 57'd0);

   always_comb begin
      case (cmd.src)
         dodenc_pkg::SRC_HDR: begin
            if (cmd.idx[2]) begin
               byte_in = block_length_ff[8*cmd.idx[1:0] +: 8];
            end else begin
               byte_in = total_items_ff[8*cmd.idx[1:0] +: 8];
            end
         end
         dodenc_pkg::SRC_CNT: byte_in = count_ff[8*cmd.idx[1:0] +: 8];
         dodenc_pkg::SRC_RAW: byte_in = stamp_ff[8*cmd.idx +: 8];
         dodenc_pkg::SRC_DLT: byte_in = delta_ff[8*cmd.idx +: 8];
         dodenc_pkg::SRC_SGN: byte_in = neg_ff ? dodenc_pkg::SIGN_NEG : dodenc_pkg::SIGN_POS;
         dodenc_pkg::SRC_VAR: begin
            byte_in = {1'b0, vval_ff[6:0]} | (var_done ? 8'h00 : dodenc_pkg::VAR_MORE);
         end
         default: byte_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_items_ff  <= 32'd1;
         block_length_ff <= 32'd1024;
         zigzag_ff       <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            dodenc_pkg::CSR_TOTAL_ITEMS:  total_items_ff  <= csr_wdata;
            dodenc_pkg::CSR_BLOCK_LENGTH: block_length_ff <= csr_wdata;
            dodenc_pkg::CSR_ZIGZAG_MODE:  zigzag_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_idx_ff  <= 32'd0;
         block_idx_ff   <= 32'd0;
         prior_stamp_ff <= 64'd0;
         prior_delta_ff <= 64'd0;
      end else begin
         if (cmd.load) begin
            prior_stamp_ff <= $unsigned(req_stamp);
            if (ends_in) begin
               stream_idx_ff <= 32'd0;
               block_idx_ff  <= 32'd0;
            end else begin
               stream_idx_ff <= stream_nxt[31:0];
               block_idx_ff  <= blk_wrap ? 32'd0 : block_nxt[31:0];
            end
         end
         if (cmd.prep) begin
            prior_delta_ff <= blk0_ff ? 64'd0 : delta_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stamp_ff <= $unsigned(req_stamp);
         delta_ff <= delta_in;
         count_ff <= count_in;
         first_ff <= (stream_idx_ff == 32'd0);
         blk0_ff  <= (block_idx_ff == 32'd0);
         blk1_ff  <= (block_idx_ff == 32'd1);
         ends_ff  <= ends_in;
      end
      if (cmd.prep) begin
         vval_ff <= vval_in;
         neg_ff  <= dod[dodenc_pkg::SIGN_BIT];
      end else if (cmd.emit && (cmd.src == dodenc_pkg::SRC_VAR)) begin
         vval_ff <= {7'd0, vval_ff[63:7]};
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= byte_in;
         rsp_last_ff <= cmd.run_last;
         rsp_end_ff  <= cmd.run_last & ends_ff;
      end
   end

   assign sts.slot_free  = ~rsp_valid_ff | rsp_ready;
   assign sts.first_item = first_ff;
   assign sts.blk0       = blk0_ff;
   assign sts.blk1       = blk1_ff;
   assign sts.zigzag     = zigzag_ff;
   assign sts.var_done   = var_done;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_stream_end = rsp_end_ff;

endmodule

// ===== rtl/dodenc_ctrl.sv =====
// Controller of the timestamp encoder: sequences the byte fields of one word.
`include "delta_of_delta_timestamp_encoder_unit_assert.svh"

module dodenc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dodenc_pkg::dodenc_sts_type sts,
   output dodenc_pkg::dodenc_cmd_type cmd
);

   dodenc_pkg::dodenc_state_type state_ff, state_in, body_st;
   logic [2:0] idx_ff, idx_in;

   // Field that follows the header, or that opens a word without one.
   always_comb begin
      if (sts.blk0) begin
         body_st = dodenc_pkg::ST_CNT;
      end else if (sts.blk1) begin
         body_st = dodenc_pkg::ST_DLT;
      end else if (sts.zigzag) begin
         body_st = dodenc_pkg::ST_VAR;
      end else begin
         body_st = dodenc_pkg::ST_SGN;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         dodenc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dodenc_pkg::ST_PREP;
            end
         end
         dodenc_pkg::ST_PREP: begin
            idx_in   = 3'd0;
            state_in = sts.first_item ? dodenc_pkg::ST_HDR : body_st;
         end
         dodenc_pkg::ST_HDR: begin
            if (sts.slot_free) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = body_st;
               end
            end
         end
         dodenc_pkg::ST_CNT: begin
            if (sts.slot_free) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd3) begin
                  idx_in   = 3'd0;
                  state_in = dodenc_pkg::ST_RAW;
               end
            end
         end
         dodenc_pkg::ST_RAW,
         dodenc_pkg::ST_DLT: begin
            if (sts.slot_free) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = dodenc_pkg::ST_IDLE;
               end
            end
         end
         dodenc_pkg::ST_SGN: begin
            if (sts.slot_free) begin
               state_in = dodenc_pkg::ST_VAR;
            end
         end
         dodenc_pkg::ST_VAR: begin
            if (sts.slot_free && sts.var_done) begin
               state_in = dodenc_pkg::ST_IDLE;
            end
         end
         default: state_in = dodenc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.prep     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.src      = dodenc_pkg::SRC_HDR;
      cmd.idx      = idx_ff;
      cmd.run_last = 1'b0;
      unique case (state_ff)
         dodenc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         dodenc_pkg::ST_PREP: cmd.prep = 1'b1;
         dodenc_pkg::ST_HDR: begin
            cmd.emit = sts.slot_free;
            cmd.src  = dodenc_pkg::SRC_HDR;
         end
         dodenc_pkg::ST_CNT: begin
            cmd.emit = sts.slot_free;
            cmd.src  = dodenc_pkg::SRC_CNT;
         end
         dodenc_pkg::ST_RAW: begin
            cmd.emit     = sts.slot_free;
            cmd.src      = dodenc_pkg::SRC_RAW;
            cmd.run_last = (idx_ff == 3'd7);
         end
         dodenc_pkg::ST_DLT: begin
            cmd.emit     = sts.slot_free;
            cmd.src      = dodenc_pkg::SRC_DLT;
            cmd.run_last = (idx_ff == 3'd7);
         end
         dodenc_pkg::ST_SGN: begin
            cmd.emit = sts.slot_free;
            cmd.src  = dodenc_pkg::SRC_SGN;
         end
         dodenc_pkg::ST_VAR: begin
            cmd.emit     = sts.slot_free;
            cmd.src      = dodenc_pkg::SRC_VAR;
            cmd.run_last = sts.var_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dodenc_pkg::ST_IDLE;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   `DODENC_ASSERT_NEXT(a_load_then_prep, clock, reset, cmd.load, state_ff == dodenc_pkg::ST_PREP, "accepted word did not enter the prepare step")
   `DODENC_ASSERT_NEXT(a_last_then_idle, clock, reset, cmd.emit && cmd.run_last, state_ff == dodenc_pkg::ST_IDLE, "controller stayed busy after the last byte of a word")
   `DODENC_ASSERT_NOW(a_cnt_idx_range, clock, reset, state_ff == dodenc_pkg::ST_CNT, idx_ff[2] == 1'b0, "count field index ran past four bytes")
   `DODENC_ASSERT_NOW(a_emit_needs_slot, clock, reset, cmd.emit, sts.slot_free, "byte emitted while the output register was still occupied")

endmodule
